>>> rtl/itr_pkg.sv
package itr_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'd122;

    // Map a digit value to its ASCII glyph: 0-9, then a-z.
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] glyph;
        if (d < DEC_DIGITS)
            glyph = CHAR_ZERO + {1'b0, d};
        else if (d < RADIX_MAX)
            glyph = CHAR_LOWER_A + {1'b0, d - DEC_DIGITS};
        else
            glyph = CHAR_ZERO;
        return glyph;
    endfunction

endpackage

>>> rtl/integer_to_radix_text.sv
// Converts a signed VALUE_WIDTH-bit integer into its text form in radix 2..36 and
// streams the ASCII characters out one beat each, most significant first, with
// last set on the final character. A negative value starts with '-'; the most
// negative value converts exactly. A radix outside 2..36, or a value of zero,
// gives the single character '0'. One input beat is taken at a time: in_ready is
// high only while the converter is idle. Digits are produced by one shared
// bit-serial divider and held in a small digit memory; each digit is then read
// from the memory and loaded into the output register. The last character may
// still wait in the output register while the next input beat is accepted.
module integer_to_radix_text #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic [itr_pkg::RADIX_W-1:0]  radix,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [itr_pkg::CHAR_W-1:0]   character,
    output logic                         last
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_SIGN,
        S_FETCH,
        S_EMIT
    } state_t;

    state_t                       state_reg;
    logic [VALUE_WIDTH-1:0]       mag_reg;
    logic [itr_pkg::RADIX_W-1:0]  radix_reg;
    logic                         neg_reg;
    logic [CNT_W-1:0]             count_reg;
    logic                         out_valid_reg;
    logic [itr_pkg::CHAR_W-1:0]   char_reg;
    logic                         last_reg;

    // digit memory, written LSD first, read back MSD first
    logic [itr_pkg::RADIX_W-1:0]  digit_mem [VALUE_WIDTH];
    logic [itr_pkg::RADIX_W-1:0]  digit_reg;

    logic                         accept;
    logic                         out_free;
    logic                         radix_ok;
    logic                         is_neg;
    logic [VALUE_WIDTH-1:0]       abs_value;
    logic [CNT_W-1:0]             count_m1;
    logic [CNT_W-1:0]             count_next;

    logic                         div_start;
    logic                         div_done;
    logic [VALUE_WIDTH-1:0]       div_quo;
    logic [itr_pkg::RADIX_W-1:0]  div_rem;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign radix_ok  = radix inside {[itr_pkg::RADIX_MIN:itr_pkg::RADIX_MAX]};
    assign is_neg    = value[VALUE_WIDTH-1];
    // unsigned negate: the most negative value maps to 2^(VALUE_WIDTH-1)
    assign abs_value = is_neg ? (~value + VALUE_WIDTH'(1)) : value;
    assign count_m1  = count_reg - CNT_W'(1);
    assign count_next = count_reg + CNT_W'(1);
    assign div_start = (state_reg == S_DIV_LOAD);

    itr_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (radix_reg),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    // Store each remainder as it arrives; read one digit back per fetch.
    always_ff @(posedge clk) begin
        if (state_reg == S_DIV_RUN && div_done)
            digit_mem[count_reg[IDX_W-1:0]] <= div_rem;
        if (state_reg == S_FETCH)
            digit_reg <= digit_mem[count_m1[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            mag_reg       <= '0;
            radix_reg     <= '0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else begin
            // drop the output beat once it is taken; a load below overrides
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        mag_reg   <= abs_value;
                        radix_reg <= radix;
                        neg_reg   <= is_neg;
                        count_reg <= '0;
                        if (!radix_ok || value == '0)
                            state_reg <= S_ZERO;
                        else
                            state_reg <= S_DIV_LOAD;
                    end
                end

                S_ZERO: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= itr_pkg::CHAR_ZERO;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                S_DIV_LOAD: begin
                    state_reg <= S_DIV_RUN;
                end

                S_DIV_RUN: begin
                    if (div_done) begin
                        mag_reg   <= div_quo;
                        count_reg <= count_next;
                        // stop once the quotient runs out of digits
                        if (div_quo != '0)
                            state_reg <= S_DIV_LOAD;
                        else if (neg_reg)
                            state_reg <= S_SIGN;
                        else
                            state_reg <= S_FETCH;
                    end
                end

                S_SIGN: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= itr_pkg::CHAR_MINUS;
                        last_reg      <= 1'b0;
                        state_reg     <= S_FETCH;
                    end
                end

                S_FETCH: begin
                    state_reg <= S_EMIT;
                end

                S_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= itr_pkg::digit_glyph(digit_reg);
                        last_reg      <= (count_reg == CNT_W'(1));
                        count_reg     <= count_m1;
                        if (count_reg == CNT_W'(1))
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_FETCH;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

>>> rtl/itr_divider.sv
// Restoring divider: one quotient bit per cycle.
module itr_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [VALUE_WIDTH-1:0]       dividend,
    input  logic [itr_pkg::RADIX_W-1:0]  divisor,
    output logic                         done,
    output logic [VALUE_WIDTH-1:0]       quotient,
    output logic [itr_pkg::RADIX_W-1:0]  remainder
);

    localparam int BIT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic                         busy_reg;
    logic                         done_reg;
    logic [BIT_W-1:0]             bit_cnt_reg;
    logic [VALUE_WIDTH-1:0]       quo_reg;
    logic [itr_pkg::RADIX_W-1:0]  rem_reg;

    logic [itr_pkg::RADIX_W:0]    trial;
    logic                         fits;
    logic [itr_pkg::RADIX_W:0]    rem_next;

    assign trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign fits     = trial >= {1'b0, divisor};
    assign rem_next = fits ? (trial - {1'b0, divisor}) : trial;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= BIT_W'(VALUE_WIDTH - 1);
                quo_reg     <= dividend;
                rem_reg     <= '0;
            end
            else if (busy_reg) begin
                // shift one dividend bit into the remainder, one quotient bit into quo_reg
                quo_reg     <= {quo_reg[VALUE_WIDTH-2:0], fits};
                rem_reg     <= rem_next[itr_pkg::RADIX_W-1:0];
                bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
                if (bit_cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/itr_checker.sv
module itr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [itr_pkg::CHAR_W-1:0]  character,
    input logic                        last
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
        else $error("stalled output beat changed");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == itr_pkg::CHAR_MINUS)
            || (character >= itr_pkg::CHAR_ZERO && character <= itr_pkg::CHAR_NINE)
            || (character >= itr_pkg::CHAR_LOWER_A && character <= itr_pkg::CHAR_LOWER_Z))
        else $error("character outside the digit alphabet");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && character == itr_pkg::CHAR_MINUS |-> !last)
        else $error("minus sign marked as last");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an accepted input beat");

    a_no_accept_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("ready while a conversion still has characters to send");

endmodule

bind integer_to_radix_text itr_checker u_itr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .last     (last)
);
